>>> design/brf_pkg.sv
// shared types, codes and defaults for the byte ring fifo
package brf_pkg;

	localparam int DEPTH_DEF     = 256;
	localparam int MAX_BURST_DEF = 64;

	localparam int OP_W   = 3;
	localparam int BYTE_W = 8;
	localparam int N_W    = 7;
	localparam int FILL_W = 9;
	localparam int STAT_W = 3;
	localparam int KIND_W = 3;

	localparam int QDEPTH = 2;

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_BURST = 3'd2;
	localparam logic [OP_W-1:0] OP_DELIM = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

	localparam logic [KIND_W-1:0] CMD_WRITE = 3'd0;
	localparam logic [KIND_W-1:0] CMD_READ  = 3'd1;
	localparam logic [KIND_W-1:0] CMD_BURST = 3'd2;
	localparam logic [KIND_W-1:0] CMD_DELIM = 3'd3;
	localparam logic [KIND_W-1:0] CMD_FLUSH = 3'd4;
	localparam logic [KIND_W-1:0] CMD_NOP   = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL       = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_ENOUGH = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] wbyte;
		logic [N_W-1:0]    n;
		logic [BYTE_W-1:0] dl;
	} cmd_t;

endpackage

>>> design/brf_front.sv
// front end: accepts items and classifies them into commands
module brf_front #(
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [brf_pkg::OP_W-1:0]    op,
	input  logic [brf_pkg::BYTE_W-1:0]  write_byte,
	input  logic [brf_pkg::N_W-1:0]     burst_count,
	input  logic [brf_pkg::BYTE_W-1:0]  delimiter_byte,
	input  logic                        q_full,
	output logic                        q_push,
	output brf_pkg::cmd_t               q_cmd
);

	localparam logic [brf_pkg::N_W-1:0] N_MAX = brf_pkg::N_W'(MAX_BURST);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.wbyte = write_byte;
		q_cmd.dl    = delimiter_byte;
		q_cmd.n     = (burst_count > N_MAX) ? N_MAX : burst_count;
		case (op)
			brf_pkg::OP_WRITE: q_cmd.kind = brf_pkg::CMD_WRITE;
			brf_pkg::OP_READ:  q_cmd.kind = brf_pkg::CMD_READ;
			brf_pkg::OP_BURST: q_cmd.kind = brf_pkg::CMD_BURST;
			brf_pkg::OP_DELIM: q_cmd.kind = brf_pkg::CMD_DELIM;
			brf_pkg::OP_FLUSH: q_cmd.kind = brf_pkg::CMD_FLUSH;
			default:           q_cmd.kind = brf_pkg::CMD_NOP;
		endcase
	end

endmodule

>>> design/brf_queue.sv
// short command queue between front and back
module brf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          cmd_valid,
	output brf_pkg::cmd_t cmd
);

	localparam int AW = (brf_pkg::QDEPTH > 1) ? $clog2(brf_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(brf_pkg::QDEPTH + 1);

	brf_pkg::cmd_t   entry_q [brf_pkg::QDEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (cnt_q == CW'(brf_pkg::QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = entry_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && cmd_valid;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(brf_pkg::QDEPTH - 1)) ? '0 : AW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= nxt(wr_q);
			end
			if (do_pop) begin
				rd_q <= nxt(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> design/brf_back.sv
// back end: ring store, pointers, scan and emit sequencer, result register
module brf_back #(
	parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [brf_pkg::FILL_W-1:0]    cfg_data,
	input  logic                          cmd_valid,
	input  brf_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [brf_pkg::BYTE_W-1:0]    read_value,
	output logic                          value_valid,
	output logic [brf_pkg::STAT_W-1:0]    status,
	output logic [brf_pkg::N_W-1:0]       taken_count,
	output logic [brf_pkg::FILL_W-1:0]    fill_level,
	output logic                          last
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = (PTR_W + 1 > brf_pkg::FILL_W + 1) ? PTR_W + 1 : brf_pkg::FILL_W + 1;
	localparam int FW    = brf_pkg::FILL_W;
	localparam int NW    = brf_pkg::N_W;
	localparam logic [FW-1:0] CAP_MAX = {FW{1'b1}};
	localparam logic [FW-1:0] CAP_RST = (DEPTH > int'(CAP_MAX)) ? CAP_MAX : FW'(DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;
	localparam logic [1:0] ST_SINGLE = 2'd3;

	logic [brf_pkg::BYTE_W-1:0] store [DEPTH];
	logic [brf_pkg::BYTE_W-1:0] mem_q;

	logic [1:0]                 state_q;
	logic [FW-1:0]              cap_q;
	logic [PTR_W-1:0]           rp_q;
	logic [PTR_W-1:0]           wp_q;
	logic [PTR_W-1:0]           sp_q;
	logic [FW-1:0]              count_q;
	logic [NW-1:0]              rem_q;
	logic [NW-1:0]              lim_q;
	logic [NW-1:0]              scan_idx_q;
	logic [NW-1:0]              taken_q;
	logic [brf_pkg::BYTE_W-1:0] dl_q;
	logic                       delim_q;
	logic [brf_pkg::STAT_W-1:0] status_q;
	logic                       rd_v_s1;
	logic [NW-1:0]              chk_idx_s1;

	logic                       ovalid_q;
	logic [brf_pkg::BYTE_W-1:0] oval_q;
	logic                       ovv_q;
	logic [brf_pkg::STAT_W-1:0] ostat_q;
	logic [NW-1:0]              otaken_q;
	logic [FW-1:0]              ofill_q;
	logic                       olast_q;

	logic                       out_free;
	logic                       full;
	logic [FW-1:0]              n9;
	logic [NW-1:0]              lim;
	logic                       found;
	logic                       scan_end;
	logic                       rd_en;
	logic [PTR_W-1:0]           rd_addr;
	logic                       wr_en;
	logic [FW-1:0]              cfg_cap;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
		input logic [FW-1:0] cap);
		logic [XW-1:0] t;
		t = XW'(p) + XW'(1);
		return (t == XW'(cap)) ? '0 : PTR_W'(t);
	endfunction

	assign out_free = !ovalid_q || !out_stall;
	assign full     = (count_q >= cap_q);
	assign n9       = FW'(cmd.n);
	assign lim      = (count_q < n9) ? NW'(count_q) : cmd.n;
	assign found    = rd_v_s1 && (mem_q == dl_q);
	assign scan_end = rd_v_s1 && (chk_idx_s1 == lim_q - 1'b1);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign cfg_cap  = (cfg_data == '0) ? FW'(1) :
		((32'(cfg_data) > 32'(DEPTH)) ? FW'(DEPTH) : cfg_data);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rp_q;
		wr_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					wr_en = (cmd.kind == brf_pkg::CMD_WRITE) && !full;
					rd_en = ((cmd.kind == brf_pkg::CMD_READ) && (count_q != '0)) ||
						((cmd.kind == brf_pkg::CMD_BURST) && !(count_q < n9) &&
						(cmd.n != '0));
				end
			end
			ST_SCAN: begin
				if (found) begin
					rd_en = (chk_idx_s1 != '0);
				end else if (!scan_end && (scan_idx_q < lim_q)) begin
					rd_en   = 1'b1;
					rd_addr = sp_q;
				end
			end
			ST_EMIT: begin
				rd_en = out_free && (rem_q != NW'(1));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wp_q] <= cmd.wbyte;
		end
		if (rd_en) begin
			mem_q <= store[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= CAP_RST;
			rp_q       <= '0;
			wp_q       <= '0;
			sp_q       <= '0;
			count_q    <= '0;
			rem_q      <= '0;
			lim_q      <= '0;
			scan_idx_q <= '0;
			taken_q    <= '0;
			dl_q       <= '0;
			delim_q    <= 1'b0;
			status_q   <= brf_pkg::STAT_OK;
			rd_v_s1    <= 1'b0;
			chk_idx_s1 <= '0;
			ovalid_q   <= 1'b0;
			oval_q     <= '0;
			ovv_q      <= 1'b0;
			ostat_q    <= brf_pkg::STAT_OK;
			otaken_q   <= '0;
			ofill_q    <= '0;
			olast_q    <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_write) begin
				cap_q   <= cfg_cap;
				rp_q    <= '0;
				wp_q    <= '0;
				count_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						status_q <= brf_pkg::STAT_OK;
						state_q  <= ST_SINGLE;
						case (cmd.kind)
							brf_pkg::CMD_WRITE: begin
								if (full) begin
									status_q <= brf_pkg::STAT_FULL;
								end else begin
									wp_q    <= adv(wp_q, cap_q);
									count_q <= count_q + 1'b1;
								end
							end
							brf_pkg::CMD_READ: begin
								if (count_q == '0) begin
									status_q <= brf_pkg::STAT_EMPTY;
								end else begin
									rp_q    <= adv(rp_q, cap_q);
									count_q <= count_q - 1'b1;
									rem_q   <= NW'(1);
									delim_q <= 1'b0;
									state_q <= ST_EMIT;
								end
							end
							brf_pkg::CMD_BURST: begin
								if (count_q < n9) begin
									status_q <= brf_pkg::STAT_NOT_ENOUGH;
								end else if (cmd.n != '0) begin
									rp_q    <= adv(rp_q, cap_q);
									count_q <= count_q - n9;
									rem_q   <= cmd.n;
									delim_q <= 1'b0;
									state_q <= ST_EMIT;
								end
							end
							brf_pkg::CMD_DELIM: begin
								if (lim == '0) begin
									status_q <= brf_pkg::STAT_NOT_FOUND;
								end else begin
									lim_q      <= lim;
									dl_q       <= cmd.dl;
									sp_q       <= rp_q;
									scan_idx_q <= '0;
									rd_v_s1    <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
							brf_pkg::CMD_FLUSH: begin
								rp_q    <= '0;
								wp_q    <= '0;
								count_q <= '0;
							end
							default: begin
								status_q <= brf_pkg::STAT_OK;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (found) begin
						rd_v_s1 <= 1'b0;
						rp_q    <= adv(rp_q, cap_q);
						count_q <= count_q - FW'(chk_idx_s1) - 1'b1;
						if (chk_idx_s1 == '0) begin
							status_q <= brf_pkg::STAT_OK;
							state_q  <= ST_SINGLE;
						end else begin
							rem_q   <= chk_idx_s1;
							taken_q <= chk_idx_s1;
							delim_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end else if (scan_end) begin
						rd_v_s1  <= 1'b0;
						status_q <= brf_pkg::STAT_NOT_FOUND;
						state_q  <= ST_SINGLE;
					end else if (scan_idx_q < lim_q) begin
						sp_q       <= adv(sp_q, cap_q);
						scan_idx_q <= scan_idx_q + 1'b1;
						rd_v_s1    <= 1'b1;
						chk_idx_s1 <= scan_idx_q;
					end else begin
						rd_v_s1 <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						oval_q   <= mem_q;
						ovv_q    <= 1'b1;
						ostat_q  <= brf_pkg::STAT_OK;
						ofill_q  <= count_q;
						olast_q  <= (rem_q == NW'(1));
						otaken_q <= ((rem_q == NW'(1)) && delim_q) ? taken_q : '0;
						if (rem_q != NW'(1)) begin
							rp_q  <= adv(rp_q, cap_q);
							rem_q <= rem_q - 1'b1;
						end else begin
							// step over the delimiter
							if (delim_q) begin
								rp_q <= adv(rp_q, cap_q);
							end
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SINGLE: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						oval_q   <= '0;
						ovv_q    <= 1'b0;
						ostat_q  <= status_q;
						otaken_q <= '0;
						ofill_q  <= count_q;
						olast_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = ovalid_q;
	assign read_value  = oval_q;
	assign value_valid = ovv_q;
	assign status      = ostat_q;
	assign taken_count = otaken_q;
	assign fill_level  = ofill_q;
	assign last        = olast_q;

endmodule

>>> design/byte_ring_fifo_with_delimiter_read.sv
// byte ring fifo with burst and delimiter reads, top level
// usage:
//   input channel (in_valid / in_stall) carries one operation per item: write a
//   byte, read a byte, read a burst, read up to a delimiter, or flush
//   output channel (out_valid / out_stall) carries one or more results per item,
//   the final one flagged by last; every result shows the fill level that holds
//   after the whole operation
//   cfg_write / cfg_data set the capacity and empty the ring; write it only while
//   no item is in flight
// timing:
//   items enter a two-entry command queue, so the input keeps taking items while
//   the back end works or the output is stalled
//   write, flush, refusals and unknown ops: 2 cycles in the back end
//   read and burst of n bytes: 1 + n cycles, one byte a cycle from the store
//   delimiter read: the scan reads one byte a cycle (about k + 2 cycles for a
//   delimiter at offset k), then emits the k bytes at one a cycle
//   the single-port byte store sets the pace of bursts and scans
// reset: the ring is empty and the capacity is DEPTH (at most 511)
// stall: a stalled result holds; the back end waits, then the queue fills and
//   in_stall rises
module byte_ring_fifo_with_delimiter_read #(
	parameter int DEPTH     = brf_pkg::DEPTH_DEF,
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [brf_pkg::FILL_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [brf_pkg::OP_W-1:0]      op,
	input  logic [brf_pkg::BYTE_W-1:0]    write_byte,
	input  logic [brf_pkg::N_W-1:0]       burst_count,
	input  logic [brf_pkg::BYTE_W-1:0]    delimiter_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [brf_pkg::BYTE_W-1:0]    read_value,
	output logic                          value_valid,
	output logic [brf_pkg::STAT_W-1:0]    status,
	output logic [brf_pkg::N_W-1:0]       taken_count,
	output logic [brf_pkg::FILL_W-1:0]    fill_level,
	output logic                          last
);

	logic          q_full;
	logic          q_push;
	brf_pkg::cmd_t q_cmd;
	logic          cmd_valid;
	logic          cmd_pop;
	brf_pkg::cmd_t cmd;

	brf_front #(
		.MAX_BURST(MAX_BURST)
	) u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.write_byte     (write_byte),
		.burst_count    (burst_count),
		.delimiter_byte (delimiter_byte),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_cmd          (q_cmd)
	);

	brf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	brf_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.value_valid (value_valid),
		.status      (status),
		.taken_count (taken_count),
		.fill_level  (fill_level),
		.last        (last)
	);

endmodule

>>> design/brf_checker.sv
// port-level checks for the byte ring fifo, bound to the top level
module brf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [brf_pkg::BYTE_W-1:0]    read_value,
	input logic                          value_valid,
	input logic [brf_pkg::STAT_W-1:0]    status,
	input logic [brf_pkg::N_W-1:0]       taken_count,
	input logic [brf_pkg::FILL_W-1:0]    fill_level,
	input logic                          last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) &&
		$stable(status) && $stable(fill_level) && $stable(last))
		else $error("stalled result changed");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_valid |-> status == brf_pkg::STAT_OK)
		else $error("popped byte with non-ok status");

	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !value_valid |-> read_value == '0 && taken_count == '0 && last)
		else $error("result without byte is malformed");

	a_taken_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && taken_count != '0 |-> last && value_valid)
		else $error("taken count off the last byte");

	a_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> value_valid && taken_count == '0 &&
		status == brf_pkg::STAT_OK)
		else $error("non-final result is not a plain byte");

endmodule

bind byte_ring_fifo_with_delimiter_read brf_checker u_brf_checker (.*);
